// ----- design/double_ended_queue_defines.svh -----
// Assertion macros shared by the double-ended queue RTL.
// Depends on nothing; included by the top level only.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/deq_pkg.sv -----
// Package for the double-ended queue: word types, command codes, FSM states.
// Used by deq_ctrl, deq_datapath and double_ended_queue.
package deq_pkg;

  localparam int DEQ_DEPTH = 64;
  localparam int WORD_W    = 32;
  localparam int FILL_W    = 7;

  // Command codes carried by each input word.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  typedef struct packed {
    deq_op_t                    cmd;
    logic signed [WORD_W-1:0]   push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   pop_value;
    logic                       empty_error;
    logic                       full_error;
    logic [FILL_W-1:0]          fill_count;
  } deq_out_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } deq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } deq_ctl_t;

endpackage

// ----- design/double_ended_queue.sv -----
// Top level of the double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_ctrl, deq_datapath and double_ended_queue_defines.svh.
//
// Usage:
//   Each input word on in_data is one command: push front, pop front, push
//   back or pop back. It is taken on a rising edge with in_valid high and
//   in_stall low. Every command gives exactly one result word on out_data,
//   taken on a rising edge with out_valid high and out_stall low.
//   A pop returns the removed value; a pop on an empty queue returns zero
//   with empty_error set, and a push on a full queue is dropped with
//   full_error set. fill_count is the number of words held afterwards,
//   kept to its low seven bits.
//   A taken command moves the controller to its load state while the store
//   read is registered; out_valid rises when the result register is loaded,
//   which waits for that register to be free. No new command is taken before
//   this load, which follows the registered read of the single-port word store.
//   A new command is taken while an earlier result still waits; a stalled
//   receiver holds the result, and the next command then waits in the core.
//   Reset (rst_n low, synchronous) empties the queue and drops any result;
//   the store contents are not cleared and need no clearing pass.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_out_t out_data
);
  import deq_pkg::*;
  `include "double_ended_queue_defines.svh"

  deq_ctl_t ctl;

  // Command sequencing.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Storage and result.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // Checks on the result word and command sequencing.
  `DEQ_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && out_data.empty_error,
    out_data.pop_value == '0 && !out_data.full_error,
    "failed pop must return zero without full flag")
  `DEQ_ASSERT_SAME(a_full_count, clk, rst_n, out_valid && out_data.full_error,
    out_data.fill_count == FILL_W'(DEPTH) && !out_data.empty_error,
    "dropped push must report a full queue")
  `DEQ_ASSERT_NEXT(a_one_cmd, clk, rst_n, in_valid && !in_stall, in_stall,
    "a second command was taken before the first finished")

endmodule

// ----- design/deq_ctrl.sv -----
// Controller for the double-ended queue: sequences accept and result load.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_ctl_t ctl
);
  import deq_pkg::*;

  deq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state: a command is executed on accept, then its result waits for
  // the output register to be free.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall     = 1'b1;
    ctl.accept   = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      ST_LOAD: begin
        ctl.load_out = !out_valid_r || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // The result register holds until the receiver takes it.
  always_comb begin
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/deq_datapath.sv -----
// Datapath for the double-ended queue: word store, front pointer, count,
// and the result register. Depends on deq_pkg.
module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  deq_pkg::deq_ctl_t ctl,
  input  deq_pkg::deq_in_t  in_data,
  output deq_pkg::deq_out_t out_data
);
  import deq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              pend_pop_ok_r;
  logic              pend_empty_r;
  logic              pend_full_r;
  deq_out_t          out_data_r;

  logic              is_full, is_empty;
  logic [PTR_W-1:0]  front_dec, front_inc;
  logic [SUM_W-1:0]  sum_push, sum_pop;
  logic [PTR_W-1:0]  back_push, back_pop;
  logic [PTR_W-1:0]  addr;
  logic              wr_en, rd_en;
  logic              empty_err, full_err;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Wrapping pointer arithmetic; each sum stays below twice the depth where it is used.
  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign sum_push  = SUM_W'(front_r) + SUM_W'(count_r);
  assign sum_pop   = SUM_W'(front_r) + SUM_W'(count_r) - 1'b1;
  assign back_push = (sum_push >= SUM_W'(DEPTH)) ? PTR_W'(sum_push - SUM_W'(DEPTH))
                                                 : PTR_W'(sum_push);
  assign back_pop  = (sum_pop >= SUM_W'(DEPTH)) ? PTR_W'(sum_pop - SUM_W'(DEPTH))
                                                : PTR_W'(sum_pop);

  // Command decode: store address, pointer updates and error flags.
  always_comb begin
    addr      = front_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    empty_err = 1'b0;
    full_err  = 1'b0;
    front_nxt = front_r;
    count_nxt = count_r;
    unique case (in_data.cmd)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          full_err = 1'b1;
        end else begin
          addr      = front_dec;
          wr_en     = ctl.accept;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          empty_err = 1'b1;
        end else begin
          addr      = front_r;
          rd_en     = ctl.accept;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          full_err = 1'b1;
        end else begin
          addr      = back_push;
          wr_en     = ctl.accept;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          empty_err = 1'b1;
        end else begin
          addr      = back_pop;
          rd_en     = ctl.accept;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        empty_err = 1'b0;
      end
    endcase
  end

  // Word store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= in_data.push_value;
    if (rd_en) rd_data_r <= mem[addr];
  end

  // Queue pointer and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (ctl.accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Flags of the command in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_pop_ok_r <= 1'b0;
      pend_empty_r  <= 1'b0;
      pend_full_r   <= 1'b0;
    end else if (ctl.accept) begin
      pend_pop_ok_r <= rd_en;
      pend_empty_r  <= empty_err;
      pend_full_r   <= full_err;
    end
  end

  // Result register; the count already holds the post-command value.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data_r.pop_value   <= pend_pop_ok_r ? rd_data_r : '0;
      out_data_r.empty_error <= pend_empty_r;
      out_data_r.full_error  <= pend_full_r;
      out_data_r.fill_count  <= FILL_W'(count_r);
    end
  end

  assign out_data = out_data_r;

endmodule

// ----- bench/tb_double_ended_queue.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the double-ended queue: directed and random command
// words with random idling on both channels, checked against an in-bench shadow deque.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
  import deq_pkg::*;

  // One pending command word, with the idle cycles to insert before it.
  typedef struct {
    deq_in_t     word;
    int unsigned gap;
    bit          drain_first;
  } pending_cmd_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_out_t out_data;

  pending_cmd_t pending_cmds[$];
  deq_out_t     expected_results[$];
  int unsigned  accepted_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  failures = 0;

  // Shadow copy of the queue contents and pointers.
  logic [WORD_W-1:0] shadow_words [DEQ_DEPTH];
  int unsigned       shadow_front = 0;
  int unsigned       shadow_count = 0;

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one command word to the shadow deque and returns the result word.
  function automatic deq_out_t apply_deque_cmd(input deq_in_t word);
    deq_out_t    res;
    int unsigned slot;
    res = '0;
    case (word.cmd)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEQ_DEPTH) begin
          res.full_error = 1'b1;
        end else begin
          shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
          shadow_words[shadow_front] = word.push_value;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.empty_error = 1'b1;
        end else begin
          res.pop_value = shadow_words[shadow_front];
          shadow_front = (shadow_front + 1) % DEQ_DEPTH;
          shadow_count--;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEQ_DEPTH) begin
          res.full_error = 1'b1;
        end else begin
          slot = (shadow_front + shadow_count) % DEQ_DEPTH;
          shadow_words[slot] = word.push_value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.empty_error = 1'b1;
        end else begin
          slot = (shadow_front + shadow_count - 1) % DEQ_DEPTH;
          res.pop_value = shadow_words[slot];
          shadow_count--;
        end
      end
    endcase
    res.fill_count = shadow_count[FILL_W-1:0];
    return res;
  endfunction

  // Idle length: mostly none or short, a few long.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Push values lean on the extremes now and then; otherwise fully random.
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(input deq_op_t op, input logic [WORD_W-1:0] value,
                           input int unsigned gap, input bit drain_first);
    pending_cmd_t item;
    item.word.cmd = op;
    item.word.push_value = value;
    item.gap = gap;
    item.drain_first = drain_first;
    pending_cmds.push_back(item);
  endtask

  task automatic note_failure(input string msg);
    if (failures < 10) $display("%t mismatch: %s", $realtime, msg);
    failures++;
  endtask

  // Driver: offers the next pending word, holds it while stalled.
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        expected_results.push_back(apply_deque_cmd(in_data));
        accepted_count <= accepted_count + 1;
      end
      if (in_valid && !fire) begin
        // Stalled: keep the word as it is.
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_cmds[0].gap != 0) begin
        pending_cmds[0].gap = pending_cmds[0].gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds[0].drain_first &&
                   (accepted_count + fire != results_seen)) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_cmds[0].word;
        in_valid <= 1'b1;
        void'(pending_cmds.pop_front());
      end
    end
  end

  // Receiver: alternating runs and stalls, plus one long hold-off.
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    int unsigned run_left;
    bit          long_hold_done;
    logic        stall_next;
    if (!rst_n) begin
      hold_left = 0;
      run_left = 0;
      long_hold_done = 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        stall_next = 1'b0;
      end else begin
        hold_left = idle_length();
        run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                 : $urandom_range(50, 150);
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Monitor: checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    deq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result word %p", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.pop_value !== want.pop_value ||
            out_data.empty_error !== want.empty_error ||
            out_data.full_error !== want.full_error ||
            out_data.fill_count !== want.fill_count) begin
          note_failure($sformatf(
            "result %0d: expected pop=%0d empty=%b full=%b fill=%0d, got pop=%0d empty=%b full=%b fill=%0d",
            results_seen, want.pop_value, want.empty_error, want.full_error,
            want.fill_count, out_data.pop_value, out_data.empty_error,
            out_data.full_error, out_data.fill_count));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned total;
    int unsigned seg_len;
    int unsigned push_pct;
    bit          calm;
    deq_op_t     op;

    // Directed: pops on empty at both ends, extreme values at both ends,
    // front pointer wrapping below zero, and pops at both ends down past empty.
    queue_cmd(OP_POP_FRONT, 32'h0, 0, 1'b0);
    queue_cmd(OP_POP_BACK, 32'hFFFF_FFFF, 0, 1'b0);
    queue_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF, 0, 1'b0);
    queue_cmd(OP_PUSH_BACK, 32'h8000_0000, 0, 1'b0);
    queue_cmd(OP_PUSH_FRONT, 32'h0000_0000, 1, 1'b0);
    queue_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF, 0, 1'b0);
    queue_cmd(OP_PUSH_FRONT, 32'h5555_5555, 0, 1'b0);
    queue_cmd(OP_PUSH_BACK, 32'hAAAA_AAAA, 2, 1'b0);
    queue_cmd(OP_POP_BACK, 32'h1234_5678, 0, 1'b0);
    queue_cmd(OP_POP_FRONT, 32'h0, 0, 1'b0);
    queue_cmd(OP_POP_BACK, 32'h0, 0, 1'b0);
    queue_cmd(OP_POP_FRONT, 32'h0, 0, 1'b0);
    queue_cmd(OP_POP_FRONT, 32'h0, 3, 1'b0);
    queue_cmd(OP_POP_BACK, 32'h0, 0, 1'b0);
    queue_cmd(OP_POP_BACK, 32'h0, 0, 1'b0);
    queue_cmd(OP_POP_FRONT, 32'h0, 0, 1'b0);
    total = 16;

    // Fill past full with random ends, then drain past empty.
    for (int i = 0; i < 70; i++) begin
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      queue_cmd(op, pick_value(), idle_length(), i == 0);
    end
    for (int i = 0; i < 70; i++) begin
      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      queue_cmd(op, pick_value(), idle_length(), 1'b0);
    end
    total += 140;

    // Random segments that lean toward filling, draining or balance.
    while (total < 1900) begin
      seg_len = $urandom_range(20, 150);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end
        queue_cmd(op, pick_value(), calm ? 0 : idle_length(),
                  i == 0 && $urandom_range(0, 5) == 0);
      end
      total += seg_len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (accepted_count != results_seen) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d result words never arrived", expected_results.size()));
    end
    if (failures == 0) begin
      $display("tb_double_ended_queue: PASS");
    end else begin
      $display("tb_double_ended_queue: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("tb_double_ended_queue: FAIL");
    $finish;
  end

endmodule
